// ===== src/integer_to_radix_digits_assert.svh =====
// assertion macros shared by the checker of the radix digit converter
`ifndef INTEGER_TO_RADIX_DIGITS_ASSERT_SVH
`define INTEGER_TO_RADIX_DIGITS_ASSERT_SVH

// same-cycle implication, muted while dis is high
`define ITRD_ASSERT_NOW(label, clk, dis, a, b) \
  label: assert property (@(posedge clk) disable iff (dis) (a) |-> (b)) \
    else $error("itrd check failed");

// next-cycle implication, muted while dis is high
`define ITRD_ASSERT_NEXT(label, clk, dis, a, b) \
  label: assert property (@(posedge clk) disable iff (dis) (a) |=> (b)) \
    else $error("itrd check failed");

`endif

// ===== src/itrd_pkg.sv =====
// shared types, constants and helpers of the radix digit converter
package itrd_pkg;

  localparam int VALUE_W      = 64;
  localparam int RADIX_W      = 8;
  localparam int BLEN_W       = 16;
  localparam int CHAR_W       = 8;
  localparam int COUNT_W      = 7;
  localparam int STORE_DEPTH  = 64;
  localparam int STORE_ADDR_W = 6;
  localparam int BITS_PER_CYC = 4;
  localparam int DIV_CYCLES   = VALUE_W / BITS_PER_CYC;
  localparam int DIV_CNT_W    = 4;

  localparam logic [BLEN_W-1:0]  MIN_BUFFER    = 16'd65;
  localparam logic [RADIX_W-1:0] DEFAULT_RADIX = 8'd10;
  localparam logic [RADIX_W-1:0] MIN_RADIX     = 8'd2;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 8'd48;
  localparam logic [CHAR_W-1:0]  CHAR_ALPHA    = 8'd55;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_DIV,
    ST_RD,
    ST_LOAD
  } state_t;

  // request to the divider
  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] dividend;
    logic [RADIX_W-1:0] divisor;
  } div_req_t;

  // answer of the divider
  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quot;
    logic [RADIX_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic                    en;
    logic [STORE_ADDR_W-1:0] addr;
    logic [CHAR_W-1:0]       data;
  } ram_wr_t;

  typedef struct packed {
    logic                    en;
    logic [STORE_ADDR_W-1:0] addr;
  } ram_rd_t;

  // digit to ascii, letters from ten up, wraps modulo 256
  function automatic logic [CHAR_W-1:0] encode_digit(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 8'd10) begin
      c = d + CHAR_ZERO;
    end else begin
      c = d + CHAR_ALPHA;
    end
    return c;
  endfunction

endpackage

// ===== src/itrd_div.sv =====
// iterative 64 by 8 bit restoring divider, four quotient bits per cycle
module itrd_div (
  input  logic             clk,
  input  logic             rst,
  input  itrd_pkg::div_req_t req,
  output itrd_pkg::div_rsp_t rsp
);

  logic [itrd_pkg::VALUE_W-1:0]   q, q_next;
  logic [itrd_pkg::RADIX_W-1:0]   r, r_next;
  logic [itrd_pkg::RADIX_W-1:0]   dvs;
  logic [itrd_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;
  logic                           done;

  // BITS_PER_CYC shift-subtract steps per cycle
  always_comb begin
    logic [itrd_pkg::RADIX_W:0]   t;
    logic [itrd_pkg::VALUE_W-1:0] qq;
    logic [itrd_pkg::RADIX_W-1:0] rr;
    qq = q;
    rr = r;
    for (int i = 0; i < itrd_pkg::BITS_PER_CYC; i++) begin
      t  = {rr, qq[itrd_pkg::VALUE_W-1]};
      qq = {qq[itrd_pkg::VALUE_W-2:0], 1'b0};
      if (t >= {1'b0, dvs}) begin
        t     = t - {1'b0, dvs};
        qq[0] = 1'b1;
      end
      rr = t[itrd_pkg::RADIX_W-1:0];
    end
    q_next = qq;
    r_next = rr;
  end

  // control of the iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == itrd_pkg::DIV_CNT_W'(itrd_pkg::DIV_CYCLES - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      q   <= req.dividend;
      r   <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      q <= q_next;
      r <= r_next;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = q;
  assign rsp.rem  = r;

endmodule

// ===== src/itrd_ram.sv =====
// digit store, one write and one registered read port
module itrd_ram (
  input  logic                          clk,
  input  itrd_pkg::ram_wr_t             wr,
  input  itrd_pkg::ram_rd_t             rd,
  output logic [itrd_pkg::CHAR_W-1:0]   rdata
);

  logic [itrd_pkg::CHAR_W-1:0] mem [itrd_pkg::STORE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

// ===== src/itrd_ctrl.sv =====
// sequencer: input transfer, digit loop, readout and output register
module itrd_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [itrd_pkg::VALUE_W-1:0]    in_value,
  input  logic [itrd_pkg::RADIX_W-1:0]    in_radix,
  input  logic [itrd_pkg::BLEN_W-1:0]     in_blen,
  output itrd_pkg::div_req_t              div_req,
  input  itrd_pkg::div_rsp_t              div_rsp,
  output itrd_pkg::ram_wr_t               ram_wr,
  output itrd_pkg::ram_rd_t               ram_rd,
  input  logic [itrd_pkg::CHAR_W-1:0]     ram_rdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [itrd_pkg::CHAR_W-1:0]     out_char,
  output logic                            out_last,
  output logic                            out_err,
  output logic [itrd_pkg::COUNT_W-1:0]    out_count
);

  itrd_pkg::state_t              state, state_next;
  logic [itrd_pkg::RADIX_W-1:0]  radix;
  logic [itrd_pkg::COUNT_W-1:0]  found;
  logic [itrd_pkg::COUNT_W-1:0]  k;
  logic [itrd_pkg::COUNT_W-1:0]  rd_idx;
  logic [itrd_pkg::RADIX_W-1:0]  radix_in;
  logic                          in_xfer;
  logic                          in_short;
  logic                          more;
  logic                          out_free;
  logic                          load_err;
  logic                          load_dig;
  logic                          last_dig;

  assign in_xfer  = s_tvalid && s_tready;
  assign in_short = in_blen < itrd_pkg::MIN_BUFFER;
  assign radix_in = (in_radix < itrd_pkg::MIN_RADIX) ? itrd_pkg::DEFAULT_RADIX : in_radix;
  assign more     = (div_rsp.quot != '0) &&
                    (found != itrd_pkg::COUNT_W'(itrd_pkg::STORE_DEPTH - 1));
  assign out_free = !m_tvalid || m_tready;
  assign last_dig = (k + 1'b1) == found;
  assign rd_idx   = found - 1'b1 - k;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      itrd_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_next = in_short ? itrd_pkg::ST_ERR : itrd_pkg::ST_DIV;
        end
      end
      itrd_pkg::ST_ERR: begin
        if (out_free) begin
          state_next = itrd_pkg::ST_IDLE;
        end
      end
      itrd_pkg::ST_DIV: begin
        if (div_rsp.done && !more) begin
          state_next = itrd_pkg::ST_RD;
        end
      end
      itrd_pkg::ST_RD: begin
        state_next = itrd_pkg::ST_LOAD;
      end
      itrd_pkg::ST_LOAD: begin
        if (out_free) begin
          state_next = last_dig ? itrd_pkg::ST_IDLE : itrd_pkg::ST_RD;
        end
      end
      default: begin
        state_next = itrd_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = div_rsp.quot;
    div_req.divisor  = radix;
    ram_wr.en        = 1'b0;
    ram_wr.addr      = found[itrd_pkg::STORE_ADDR_W-1:0];
    ram_wr.data      = itrd_pkg::encode_digit(div_rsp.rem);
    ram_rd.en        = 1'b0;
    ram_rd.addr      = rd_idx[itrd_pkg::STORE_ADDR_W-1:0];
    load_err         = 1'b0;
    load_dig         = 1'b0;
    case (state)
      itrd_pkg::ST_IDLE: begin
        s_tready         = 1'b1;
        div_req.start    = s_tvalid && !in_short;
        div_req.dividend = in_value;
        div_req.divisor  = radix_in;
      end
      itrd_pkg::ST_ERR: begin
        load_err = out_free;
      end
      itrd_pkg::ST_DIV: begin
        ram_wr.en     = div_rsp.done;
        div_req.start = div_rsp.done && more;
      end
      itrd_pkg::ST_RD: begin
        ram_rd.en = 1'b1;
      end
      itrd_pkg::ST_LOAD: begin
        load_dig = out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // state, digit count and readout index
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itrd_pkg::ST_IDLE;
      found <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      if (in_xfer) begin
        found <= '0;
        k     <= '0;
      end else if (ram_wr.en) begin
        found <= found + 1'b1;
      end else if (load_dig) begin
        k <= k + 1'b1;
      end
    end
  end

  // radix of the running conversion
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      radix <= radix_in;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_err || load_dig) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (load_err) begin
      out_char  <= '0;
      out_last  <= 1'b1;
      out_err   <= 1'b1;
      out_count <= '0;
    end else if (load_dig) begin
      out_char  <= ram_rdata;
      out_last  <= last_dig;
      out_err   <= 1'b0;
      out_count <= found;
    end
  end

endmodule

// ===== src/integer_to_radix_digits.sv =====
// top level of the radix digit converter
//
//  channel | dir | payload                                   | handshake
//  s_      | in  | tdata: value, radix, buffer_length        | s_tvalid / s_tready
//  m_      | out | tdata: digit_char, digit_count; tlast, tuser| m_tvalid / m_tready
//
// each digit comes from one pass through the shared divider (4 quotient bits a cycle),
// then each character is read out through the digit store read port.
// rst is synchronous and clears the sequencer, the divider control and the output valid.
// a stalled m_ side holds the readout; one item is worked on at a time,
// and the next input transfer is taken while the final result still waits.
module integer_to_radix_digits (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // value[63:0], radix[71:64], buffer_length[87:72]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // digit_char[7:0], digit_count[14:8], zero[15]
  output logic        m_tlast,   // last
  output logic        m_tuser    // too_small
);

  itrd_pkg::div_req_t            div_req;
  itrd_pkg::div_rsp_t            div_rsp;
  itrd_pkg::ram_wr_t             ram_wr;
  itrd_pkg::ram_rd_t             ram_rd;
  logic [itrd_pkg::CHAR_W-1:0]   ram_rdata;
  logic [itrd_pkg::CHAR_W-1:0]   out_char;
  logic [itrd_pkg::COUNT_W-1:0]  out_count;

  itrd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .in_value  (s_tdata[63:0]),
    .in_radix  (s_tdata[71:64]),
    .in_blen   (s_tdata[87:72]),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .ram_wr    (ram_wr),
    .ram_rd    (ram_rd),
    .ram_rdata (ram_rdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .out_char  (out_char),
    .out_last  (m_tlast),
    .out_err   (m_tuser),
    .out_count (out_count)
  );

  itrd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  itrd_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .rd    (ram_rd),
    .rdata (ram_rdata)
  );

  // pack result fields
  assign m_tdata = {1'b0, out_count, out_char};

endmodule

// ===== src/itrd_checker.sv =====
// port-level checks of the radix digit converter, bound to the top level
`include "integer_to_radix_digits_assert.svh"

module itrd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  // an error result is alone, empty and final
  `ITRD_ASSERT_NOW(a_err_form, clk, rst, m_tvalid && m_tuser, m_tlast && m_tdata == 16'd0)

  // a digit result carries a count from one to sixty-four
  `ITRD_ASSERT_NOW(a_count_range, clk, rst, m_tvalid && !m_tuser, m_tdata[14:8] != 7'd0 && m_tdata[14:8] <= 7'd64 && !m_tdata[15])

  // a stalled result holds
  `ITRD_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

  // reset empties the output register
  `ITRD_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !m_tvalid)

endmodule

bind integer_to_radix_digits itrd_checker u_itrd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
